// File: sv/vrts_pkg.sv
package vrts_pkg;

    // Fixed formats
    localparam int CoordWidth  = 32;
    localparam int CwEff       = (CoordWidth > 32) ? 32 : ((CoordWidth < 16) ? 16 : CoordWidth);
    localparam int TrigIterations = 16;
    localparam int LaneDepth   = 5;
    localparam int DegFull     = 180;
    localparam int TurnQ8      = 2 * DegFull * 256;
    localparam int QuarterQ8   = DegFull * 128;
    localparam logic [23:0] DegToRad = 24'd9370165;
    localparam logic signed [33:0] GainInv = 34'sh026DD3B6A;
    localparam logic signed [31:0] OneQ30  = 32'sh4000_0000;
    localparam logic signed [45:0] SatHi   = (46'sd1 <<< (CwEff - 1)) - 46'sd1;
    localparam logic signed [45:0] SatLo   = -SatHi - 46'sd1;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } vrts_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               clipped;
    } vrts_out_t;

    typedef enum logic [2:0] {
        REG_ANGLE_X = 3'd0,
        REG_ANGLE_Y = 3'd1,
        REG_ANGLE_Z = 3'd2,
        REG_MOVE_X  = 3'd3,
        REG_MOVE_Y  = 3'd4,
        REG_MOVE_Z  = 3'd5,
        REG_SCALE   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_RAD,
        ST_ROT,
        ST_STORE,
        ST_MUL,
        ST_ACC
    } seq_state_t;

    // Arctangent table, Q2.30 radians
    function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
        logic signed [32:0] v;
        begin
            case (i)
                5'd0:  v = 33'sh03243F6A8;
                5'd1:  v = 33'sh01DAC6705;
                5'd2:  v = 33'sh00FADBAFC;
                5'd3:  v = 33'sh007F56EA6;
                5'd4:  v = 33'sh003FEAB76;
                5'd5:  v = 33'sh001FFD55B;
                5'd6:  v = 33'sh000FFFAAA;
                5'd7:  v = 33'sh0007FFF55;
                5'd8:  v = 33'sh0003FFFEA;
                5'd9:  v = 33'sh0001FFFFD;
                5'd10: v = 33'sh0000FFFFF;
                5'd11: v = 33'sh00007FFFF;
                5'd12: v = 33'sh00003FFFF;
                5'd13: v = 33'sh00001FFFF;
                5'd14: v = 33'sh00000FFFF;
                5'd15: v = 33'sh000007FFF;
                5'd16: v = 33'sh000003FFF;
                5'd17: v = 33'sh000001FFF;
                5'd18: v = 33'sh000000FFF;
                5'd19: v = 33'sh0000007FF;
                5'd20: v = 33'sh0000003FF;
                5'd21: v = 33'sh0000001FF;
                5'd22: v = 33'sh0000000FF;
                5'd23: v = 33'sh00000007F;
                5'd24: v = 33'sh00000003F;
                5'd25: v = 33'sh00000001F;
                5'd26: v = 33'sh00000000F;
                5'd27: v = 33'sh000000008;
                5'd28: v = 33'sh000000004;
                5'd29: v = 33'sh000000002;
                default: v = 33'sh000000000;
            endcase
            return v;
        end
    endfunction

    // Element of an axis rotation matrix, row-major index
    function automatic logic signed [31:0] rot_el(input axis_t axis, input logic [3:0] idx,
                                                  input logic signed [31:0] c,
                                                  input logic signed [31:0] s);
        logic signed [31:0] v;
        begin
            v = '0;
            case (axis)
                AXIS_X:
                begin
                    case (idx)
                        4'd0:    v = OneQ30;
                        4'd4:    v = c;
                        4'd5:    v = s;
                        4'd7:    v = -s;
                        4'd8:    v = c;
                        default: v = '0;
                    endcase
                end
                AXIS_Y:
                begin
                    case (idx)
                        4'd0:    v = c;
                        4'd2:    v = -s;
                        4'd4:    v = OneQ30;
                        4'd6:    v = s;
                        4'd8:    v = c;
                        default: v = '0;
                    endcase
                end
                AXIS_Z:
                begin
                    case (idx)
                        4'd0:    v = c;
                        4'd1:    v = s;
                        4'd3:    v = -s;
                        4'd4:    v = c;
                        4'd8:    v = OneQ30;
                        default: v = '0;
                    endcase
                end
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: sv/vrts_build.sv
module vrts_build import vrts_pkg::*; #(
    parameter int TRIG_ITERATIONS = TrigIterations
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  busy,
    output logic [8:0][31:0]      matrix
);

    localparam int IterEff = (TRIG_ITERATIONS > 30) ? 30 :
                             ((TRIG_ITERATIONS < 1) ? 1 : TRIG_ITERATIONS);
    localparam int ItW = $clog2(IterEff + 1);

    seq_state_t state_reg, state_next;

    logic signed [17:0] angle_reg [3];
    logic signed [31:0] c_reg [3];
    logic signed [31:0] s_reg [3];
    logic [1:0]         axis_reg;
    logic [1:0]         quad_reg;
    logic [14:0]        frac_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;
    logic [ItW-1:0]     it_reg;
    logic               pass_reg;
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] t_reg [9];
    logic signed [31:0] m_reg [9];

    logic               angle_wr;
    logic signed [19:0] wrap;
    logic [16:0]        red;
    logic [1:0]         quad;
    logic [16:0]        frac;
    logic [38:0]        rad_full;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [31:0] c0;
    logic signed [31:0] s0;
    logic signed [31:0] c_map;
    logic signed [31:0] s_map;
    logic [3:0]         a_idx;
    logic [3:0]         b_idx;
    logic [3:0]         e_idx;
    logic signed [31:0] a_el;
    logic signed [31:0] b_el;
    logic signed [65:0] acc_sum;
    logic signed [35:0] rnd;
    logic signed [31:0] entry;
    logic               last_k;
    logic               last_e;

    assign angle_wr = cfg_we && ((cfg_index == REG_ANGLE_X) || (cfg_index == REG_ANGLE_Y)
                                 || (cfg_index == REG_ANGLE_Z));

    // Reduce angle into a quadrant and a residue
    always_comb
    begin
        wrap = 20'(angle_reg[axis_reg]);
        if (wrap < 0)
        begin
            wrap = wrap + 20'(TurnQ8);
        end
        if (wrap < 0)
        begin
            wrap = wrap + 20'(TurnQ8);
        end
        if (wrap >= 20'sd92160)
        begin
            wrap = wrap - 20'(TurnQ8);
        end
        red = wrap[16:0];
        if (red >= 17'(3 * QuarterQ8))
        begin
            quad = 2'd3;
            frac = red - 17'(3 * QuarterQ8);
        end
        else if (red >= 17'(2 * QuarterQ8))
        begin
            quad = 2'd2;
            frac = red - 17'(2 * QuarterQ8);
        end
        else if (red >= 17'(QuarterQ8))
        begin
            quad = 2'd1;
            frac = red - 17'(QuarterQ8);
        end
        else
        begin
            quad = 2'd0;
            frac = red;
        end
    end

    assign rad_full = 39'(frac_reg) * 39'(DegToRad);
    assign x_sh     = x_reg >>> it_reg;
    assign y_sh     = y_reg >>> it_reg;

    // Map residue result into its quadrant
    always_comb
    begin
        c0 = x_reg[31:0];
        s0 = y_reg[31:0];
        case (quad_reg)
            2'd0:
            begin
                c_map = c0;
                s_map = s0;
            end
            2'd1:
            begin
                c_map = -s0;
                s_map = c0;
            end
            2'd2:
            begin
                c_map = -c0;
                s_map = -s0;
            end
            default:
            begin
                c_map = s0;
                s_map = -c0;
            end
        endcase
    end

    // Select operands of the matrix product
    always_comb
    begin
        a_idx = 4'({row_reg, 1'b0}) + 4'(row_reg) + 4'(k_reg);
        b_idx = 4'({k_reg, 1'b0}) + 4'(k_reg) + 4'(col_reg);
        e_idx = 4'({row_reg, 1'b0}) + 4'(row_reg) + 4'(col_reg);
        if (!pass_reg)
        begin
            a_el = rot_el(AXIS_X, a_idx, c_reg[0], s_reg[0]);
            b_el = rot_el(AXIS_Y, b_idx, c_reg[1], s_reg[1]);
        end
        else
        begin
            a_el = t_reg[a_idx];
            b_el = rot_el(AXIS_Z, b_idx, c_reg[2], s_reg[2]);
        end
        acc_sum = acc_reg + 66'(prod_reg);
        rnd     = 36'((acc_sum + 66'sd536870912) >>> 30);
        if (rnd > 36'sd2147483647)
        begin
            entry = 32'sh7FFF_FFFF;
        end
        else if (rnd < -36'sd2147483648)
        begin
            entry = 32'sh8000_0000;
        end
        else
        begin
            entry = rnd[31:0];
        end
        last_k = (k_reg == 2'd2);
        last_e = (row_reg == 2'd2) && (col_reg == 2'd2);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_ANGLE: state_next = ST_RAD;
            ST_RAD:   state_next = (frac_reg == '0) ? ST_STORE : ST_ROT;
            ST_ROT:   state_next = (it_reg == ItW'(IterEff - 1)) ? ST_STORE : ST_ROT;
            ST_STORE: state_next = (axis_reg == AXIS_Z) ? ST_MUL : ST_ANGLE;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (last_k && last_e && pass_reg) ? ST_IDLE : ST_MUL;
            default:  state_next = ST_IDLE;
        endcase
        if (angle_wr)
        begin
            state_next = ST_ANGLE;
        end
    end

    // Outputs
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        for (int i = 0; i < 9; i++)
        begin
            matrix[i] = m_reg[i];
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                angle_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= ((i % 4) == 0) ? OneQ30 : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (angle_wr)
            begin
                angle_reg[cfg_index[1:0]] <= cfg_data[17:0];
            end
            if ((state_reg == ST_ACC) && last_k && pass_reg)
            begin
                m_reg[e_idx] <= entry;
            end
        end
    end

    // Advance the sequencer datapath
    always_ff @(posedge clk)
    begin
        if (angle_wr)
        begin
            axis_reg <= AXIS_X;
        end
        else
        begin
            case (state_reg)
                ST_ANGLE:
                begin
                    quad_reg <= quad;
                    frac_reg <= frac[14:0];
                end
                ST_RAD:
                begin
                    if (frac_reg == '0)
                    begin
                        x_reg <= 34'(OneQ30);
                        y_reg <= '0;
                    end
                    else
                    begin
                        x_reg <= GainInv;
                        y_reg <= '0;
                        z_reg <= 33'(rad_full[38:7]);
                    end
                    it_reg <= '0;
                end
                ST_ROT:
                begin
                    if (!z_reg[32])
                    begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_q30(5'(it_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_q30(5'(it_reg));
                    end
                    it_reg <= it_reg + 1'b1;
                end
                ST_STORE:
                begin
                    c_reg[axis_reg] <= c_map;
                    s_reg[axis_reg] <= s_map;
                    axis_reg        <= axis_reg + 2'd1;
                    pass_reg        <= 1'b0;
                    row_reg         <= '0;
                    col_reg         <= '0;
                    k_reg           <= '0;
                    acc_reg         <= '0;
                end
                ST_MUL:
                begin
                    prod_reg <= a_el * b_el;
                end
                ST_ACC:
                begin
                    if (last_k)
                    begin
                        if (!pass_reg)
                        begin
                            t_reg[e_idx] <= entry;
                        end
                        acc_reg <= '0;
                        k_reg   <= '0;
                        if (last_e)
                        begin
                            pass_reg <= 1'b1;
                            row_reg  <= '0;
                            col_reg  <= '0;
                        end
                        else if (col_reg == 2'd2)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        k_reg   <= k_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: sv/vrts_lane.sv
module vrts_lane import vrts_pkg::*; (
    input  logic                     clk,
    input  logic [2:0][31:0]         row,
    input  vrts_in_t                 vertex,
    input  logic signed [31:0]       move,
    input  logic [23:0]              scale,
    output logic signed [31:0]       coord,
    output logic                     clip
);

    logic signed [63:0] p_reg [3];
    logic signed [65:0] sum_reg;
    logic signed [36:0] q_reg;
    logic signed [61:0] sp_reg;
    logic signed [31:0] coord_reg;
    logic               clip_reg;

    logic signed [31:0] v [3];
    logic signed [35:0] rnd;
    logic signed [45:0] res;

    assign v[0] = vertex.vertex_x;
    assign v[1] = vertex.vertex_y;
    assign v[2] = vertex.vertex_z;
    assign rnd  = 36'((sum_reg + 66'sd536870912) >>> 30);
    assign res  = 46'((sp_reg + 62'sd32768) >>> 16);

    // Multiply, sum, round and translate, scale, saturate
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_reg[k] <= $signed(row[k]) * v[k];
        end
        sum_reg <= 66'(p_reg[0]) + 66'(p_reg[1]) + 66'(p_reg[2]);
        q_reg   <= 37'(rnd) + 37'(move);
        sp_reg  <= 62'(q_reg) * 62'($signed({1'b0, scale}));
        if (res > SatHi)
        begin
            coord_reg <= 32'(SatHi);
            clip_reg  <= 1'b1;
        end
        else if (res < SatLo)
        begin
            coord_reg <= 32'(SatLo);
            clip_reg  <= 1'b1;
        end
        else
        begin
            coord_reg <= res[31:0];
            clip_reg  <= 1'b0;
        end
    end

    assign coord = coord_reg;
    assign clip  = clip_reg;

endmodule

// File: sv/vertex_rotate_translate_scale_top.sv
// Affine vertex transform: out = scale * (M * v + move), saturated per coordinate.
// Input: a vertex is transferred at a rising edge with start high and busy low.
// Output: done strobes for one cycle with result valid; the receiver cannot stall,
// so each result must be taken in that cycle.
// Throughput: one vertex per cycle can be accepted while busy is low, set by three
// row lanes of 32x32 multipliers in lockstep.
// Configuration: write cfg_data to register cfg_index with cfg_we high. Writing any
// angle rebuilds M = Rx*Ry*Rz with one iterative CORDIC unit and one multiplier;
// while it does so busy is high and no vertex is accepted. Write configuration
// only while no vertex is in flight.
// Reset: angles and moves cleared, scale 1.0, M the identity, pipeline emptied.
module vertex_rotate_translate_scale_top import vrts_pkg::*; #(
    parameter int TRIG_ITERATIONS = TrigIterations
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  vrts_in_t    vertex,
    output logic        done,
    output vrts_out_t   result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [8:0][31:0]   matrix;
    logic signed [31:0] move_reg [3];
    logic [23:0]        scale_reg;
    logic [LaneDepth-1:0] valid_reg;
    logic signed [31:0] coord [3];
    logic [2:0]         clip;
    logic               accept;

    assign accept = start && !busy;

    vrts_build #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .matrix    (matrix)
    );

    // One lane per output row
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vrts_lane u_lane (
            .clk    (clk),
            .row    (matrix[3*i+2 -: 3]),
            .vertex (vertex),
            .move   (move_reg[i]),
            .scale  (scale_reg),
            .coord  (coord[i]),
            .clip   (clip[i])
        );
    end

    // Hold translation and scale registers, advance the valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                move_reg[i] <= '0;
            end
            scale_reg <= 24'd65536;
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LaneDepth-2:0], accept};
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MOVE_X: move_reg[0] <= cfg_data;
                    REG_MOVE_Y: move_reg[1] <= cfg_data;
                    REG_MOVE_Z: move_reg[2] <= cfg_data;
                    REG_SCALE:  scale_reg   <= cfg_data[23:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Merge lane results
    always_comb
    begin
        done           = valid_reg[LaneDepth-1];
        result.out_x   = coord[0];
        result.out_y   = coord[1];
        result.out_z   = coord[2];
        result.clipped = |clip;
    end

endmodule
